### src/pta_pkg.sv
// Shared constants, types and entry update functions for the page table with aging.
// Depends on nothing; pta_valid_bits and page_table_with_aging refer to it by scoped names.
package pta_pkg;

    localparam int PAGES   = 256;
    localparam int PAGE_W  = $clog2(PAGES);
    localparam int FRAME_W = 8;
    localparam int AGE_W   = 8;
    localparam int KIND_W  = 3;

    localparam logic [KIND_W-1:0] KIND_LOOKUP    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_MAP       = 3'd1;
    localparam logic [KIND_W-1:0] KIND_UNMAP     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_REFERENCE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_AGE       = 3'd4;

    localparam logic [AGE_W-1:0] AGE_TOP_BIT = 8'h80;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic               referenced;
        logic [AGE_W-1:0]   age;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame;
        logic [AGE_W-1:0]   age;
    } t_result;

    // Write command for the valid bit array.
    typedef struct packed {
        logic              we;
        logic [PAGE_W-1:0] addr;
        logic              val;
    } t_vcmd;

    // One aging step: shift right, reference bit into the top, clear the reference bit.
    function automatic t_entry age_step(input t_entry e);
        t_entry r;
        r            = e;
        r.age        = (e.age >> 1) | (e.referenced ? AGE_TOP_BIT : '0);
        r.referenced = 1'b0;
        return r;
    endfunction

    // An entry that is not valid reads as frame zero, age zero.
    function automatic t_result make_result(input logic v, input t_entry e);
        t_result r;
        r.hit   = v;
        r.frame = v ? e.frame : '0;
        r.age   = v ? e.age : '0;
        return r;
    endfunction

endpackage

### src/pta_entry_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
// Holds the frame, reference bit and age of each page; no reset of its contents.
module pta_entry_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 17
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

### src/pta_valid_bits.sv
// Valid bit of every page, held in flip-flops so that reset clears the table at once.
// Depends on pta_pkg for the page count and the write command type.
module pta_valid_bits (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  pta_pkg::t_vcmd            i_cmd,
    input  logic [pta_pkg::PAGE_W-1:0] i_raddr,
    output logic                      o_valid
);

    logic [pta_pkg::PAGES-1:0] r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.we) begin
            r_valid[i_cmd.addr] <= i_cmd.val;
        end
    end

    assign o_valid = r_valid[i_raddr];

endmodule

### src/page_table_with_aging.sv
// Top level of the page table with aging: sequencer, entry RAM, valid bits, output register.
// Depends on pta_pkg, pta_entry_ram and pta_valid_bits.
//
//  channel   direction  tdata (low bit first)            tuser
//  s_axis    in         page_number[7:0], frame[15:8]    kind[2:0]
//  m_axis    out        frame_out[7:0], age_out[15:8]    hit[0]
//
// A lookup, map, unmap or reference reads the entry RAM as it is taken, then modifies
// and writes it back; no new word is taken until that is done.
// An age tick walks the whole RAM one entry a cycle.
// The result sits in an output register, so the next word is taken while it waits;
// a stalled output only holds the sequencer once a second result is ready.
// Reset is synchronous and clears all valid bits at once; no clearing pass is needed.
module page_table_with_aging (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // page_number[7:0], frame_number[15:8]
    input  logic [2:0]  s_axis_tuser,   // kind[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // frame_out[7:0], age_out[15:8]
    output logic [0:0]  m_axis_tuser    // hit[0]
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MOD  = 2'd1;
    localparam logic [1:0] S_AGE  = 2'd2;
    localparam logic [1:0] S_HOLD = 2'd3;

    localparam logic [pta_pkg::PAGE_W-1:0] LAST_PAGE = pta_pkg::PAGE_W'(pta_pkg::PAGES - 1);

    logic [1:0]                      r_state, n_state;
    logic [pta_pkg::KIND_W-1:0]      r_kind, n_kind;
    logic [pta_pkg::PAGE_W-1:0]      r_page, n_page;
    logic [pta_pkg::FRAME_W-1:0]     r_frame, n_frame;
    logic [pta_pkg::PAGE_W-1:0]      r_idx, n_idx;
    pta_pkg::t_result                r_res, n_res;
    pta_pkg::t_result                r_out, n_out;
    logic                            r_out_valid, n_out_valid;

    logic                            ram_we;
    logic [pta_pkg::PAGE_W-1:0]      ram_waddr;
    pta_pkg::t_entry                 ram_wdata;
    logic                            ram_re;
    logic [pta_pkg::PAGE_W-1:0]      ram_raddr;
    pta_pkg::t_entry                 ram_rdata;

    pta_pkg::t_vcmd                  vcmd;
    logic [pta_pkg::PAGE_W-1:0]      v_raddr;
    logic                            v_rd;

    pta_pkg::t_entry                 upd;
    logic                            nv;
    pta_pkg::t_result                res;
    logic                            out_free;

    pta_entry_ram #(
        .DEPTH (pta_pkg::PAGES),
        .WIDTH (pta_pkg::ENTRY_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    pta_valid_bits u_valid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (vcmd),
        .i_raddr (v_raddr),
        .o_valid (v_rd)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign out_free      = !r_out_valid || m_axis_tready;
    assign v_raddr       = (r_state == S_AGE) ? r_idx : r_page;
    assign ram_wdata     = upd;

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_page      = r_page;
        n_frame     = r_frame;
        n_idx       = r_idx;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !m_axis_tready;
        ram_we      = 1'b0;
        ram_waddr   = r_page;
        ram_re      = 1'b0;
        ram_raddr   = s_axis_tdata[pta_pkg::PAGE_W-1:0];
        vcmd        = '0;
        upd         = ram_rdata;
        nv          = v_rd;
        res         = pta_pkg::make_result(nv, upd);

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_kind  = s_axis_tuser;
                    n_page  = s_axis_tdata[pta_pkg::PAGE_W-1:0];
                    n_frame = s_axis_tdata[15:8];
                    ram_re  = 1'b1;
                    if (s_axis_tuser == pta_pkg::KIND_AGE) begin
                        ram_raddr = '0;
                        n_idx     = '0;
                        n_state   = S_AGE;
                    end else begin
                        n_state = S_MOD;
                    end
                end
            end
            S_MOD: begin
                case (r_kind)
                    pta_pkg::KIND_MAP: begin
                        upd.frame      = r_frame;
                        upd.referenced = 1'b0;
                        upd.age        = '0;
                        nv             = 1'b1;
                    end
                    pta_pkg::KIND_UNMAP: begin
                        upd = '0;
                        nv  = 1'b0;
                    end
                    pta_pkg::KIND_REFERENCE: begin
                        if (v_rd) begin
                            upd.referenced = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
                ram_we    = 1'b1;
                ram_waddr = r_page;
                vcmd.we   = 1'b1;
                vcmd.addr = r_page;
                vcmd.val  = nv;
                res       = pta_pkg::make_result(nv, upd);
                if (out_free) begin
                    n_out       = res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    n_res   = res;
                    n_state = S_HOLD;
                end
            end
            S_AGE: begin
                // Entry r_idx is in the read register; entry r_idx + 1 is read meanwhile.
                upd       = pta_pkg::age_step(ram_rdata);
                ram_we    = v_rd;
                ram_waddr = r_idx;
                res       = pta_pkg::make_result(v_rd, upd);
                if (r_idx == r_page) begin
                    n_res = res;
                end
                if (r_idx == LAST_PAGE) begin
                    n_state = S_HOLD;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = pta_pkg::PAGE_W'(r_idx + 1'b1);
                    n_idx     = pta_pkg::PAGE_W'(r_idx + 1'b1);
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_page  <= n_page;
        r_frame <= n_frame;
        r_idx   <= n_idx;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = {r_out.age, r_out.frame};
    assign m_axis_tuser[0] = r_out.hit;

endmodule

### src/pta_checker.sv
// Port-level checks for the page table with aging, bound to the top level.
// Depends only on the ports of page_table_with_aging.
module pta_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    // A stalled result word stays offered.
    a_out_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word withdrawn while stalled");

    // A stalled result word keeps its contents.
    a_out_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // A miss shows frame zero and age zero.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 16'd0)
        else $error("miss carries a non-zero frame or age");

    // Every accepted word closes the input for its read-modify-write, so no word is taken right after it.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while the previous word is still in work");

endmodule

bind page_table_with_aging pta_checker u_pta_checker (.*);
